FILE: hdl/fpll_pkg.sv
// Shared types, constants and the filter band lookup for the PLL register calculator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fpll_pkg;

   // Default limits of the calculation
   localparam logic [31:0] FREQ_MIN_DEF  = 32'd34375000;
   localparam logic [31:0] FREQ_MAX_DEF  = 32'd4294967295;
   localparam logic [11:0] MOD_LIMIT_DEF = 12'd4095;
   localparam logic [9:0]  R_LIMIT_DEF   = 10'd1023;

   // Serial divider operand widths
   localparam int DIV_NUM_W = 50;
   localparam int DIV_DEN_W = 40;

   // Fixed numbers of the calculation
   localparam logic [31:0] VCO_LOW_HZ   = 32'd2200000000;
   localparam logic [31:0] PRESCALE_HZ  = 32'd3600000000;
   localparam logic [16:0] BAND_CLK_HZ  = 17'd125000;
   localparam logic [13:0] CLK_DIV_UNIT = 14'd10000;
   localparam logic [7:0]  BSC_MAX      = 8'd254;
   localparam logic [11:0] CLK_MAX      = 12'd4095;
   localparam logic [31:0] R5_WORD      = (32'd1 << 22) | (32'd3 << 19) | 32'd5;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_REF_FREQ    = 3'd0,
      CSR_REF_DOUBLER = 3'd1,
      CSR_CHAN_STEP   = 3'd2,
      CSR_POWER_LEVEL = 3'd3,
      CSR_POWER_DOWN  = 3'd4
   } csr_index_type;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_FREQ_RANGE = 3'd1,
      STATUS_STEP_SMALL = 3'd2,
      STATUS_MOD_RANGE  = 3'd3,
      STATUS_FRAC_RANGE = 3'd4,
      STATUS_N_RANGE    = 3'd5
   } status_type;

   // Tunable filter band from output frequency; the 760 to 770 MHz gap maps to 15
   function automatic logic [3:0] filter_band(input logic [31:0] f);
      logic [3:0] b;
      begin
         if      (f <= 32'd540000000)  b = 4'd0;
         else if (f <= 32'd590000000)  b = 4'd1;
         else if (f <= 32'd630000000)  b = 4'd2;
         else if (f <= 32'd660000000)  b = 4'd4;
         else if (f <= 32'd690000000)  b = 4'd5;
         else if (f <= 32'd760000000)  b = 4'd6;
         else if (f <= 32'd770000000)  b = 4'd15;
         else if (f <= 32'd1040000000) b = 4'd7;
         else if (f <= 32'd1140000000) b = 4'd8;
         else if (f <= 32'd1190000000) b = 4'd9;
         else if (f <= 32'd1240000000) b = 4'd10;
         else if (f <= 32'd1340000000) b = 4'd11;
         else if (f <= 32'd1490000000) b = 4'd12;
         else if (f <= 32'd1590000000) b = 4'd13;
         else if (f <= 32'd1690000000) b = 4'd14;
         else                          b = 4'd15;
         return b;
      end
   endfunction

endpackage
`default_nettype wire

FILE: hdl/fpll_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module fpll_div #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 40
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic                  done,
   output logic [NUM_W-1:0]      quot,
   output logic [DEN_W-1:0]      rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One trial subtraction a cycle
   assign trial = {r_ff, q_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         zero_in = (den == '0);
         cnt_in  = CNT_W'(NUM_W);
         q_in    = num;
         r_in    = '0;
         d_in    = den;
      end else if (busy_ff) begin
         r_in   = fits ? DEN_W'(trial - {1'b0, d_ff}) : trial[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      zero_ff <= zero_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
   end

   // Division by zero gives zero quotient and remainder
   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = zero_ff ? '0 : q_ff;
   assign rem  = zero_ff ? '0 : r_ff;

`ifndef SYNTHESIS
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      done_ff && !zero_ff |-> r_ff < d_ff) else $error("remainder not below divisor");
   a_cnt_load : assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == CNT_W'(NUM_W)) else $error("bad bit count");
`endif

endmodule
`default_nettype wire

FILE: hdl/frac_n_pll_register_calc.sv
// Fractional-N PLL register calculator: sequencer, operand set-up and word emission.
// Depends on fpll_pkg and fpll_div.
// Sequence: a full set runs six to about twenty-seven serial divisions, each through set-up,
// start, one bit step per quotient bit, done and post; raising R and the gcd loop set the
// spread, then one word per cycle out unless rsp_ready stalls it. Rejections end earlier.
// A fast scan takes two divisions and gives one word.
// Throughput: one transaction at a time; the shared bit-serial divider sets the rate.
// Reset: synchronous; control, configuration and persistent registers return to their defaults, r_counter 1, divider 1.
`timescale 1ns / 1ps
`default_nettype none
module frac_n_pll_register_calc #(
   parameter logic [31:0] FREQ_MIN  = fpll_pkg::FREQ_MIN_DEF,
   parameter logic [31:0] FREQ_MAX  = fpll_pkg::FREQ_MAX_DEF,
   parameter logic [11:0] MOD_LIMIT = fpll_pkg::MOD_LIMIT_DEF,
   parameter logic [9:0]  R_LIMIT   = fpll_pkg::R_LIMIT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_target_freq,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_reg_word,
   output logic [2:0]       rsp_reg_number,
   output logic             rsp_filter_select,
   output logic             rsp_last_word,
   output logic [2:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int NW = fpll_pkg::DIV_NUM_W;
   localparam int DW = fpll_pkg::DIV_DEN_W;
   localparam logic [11:0] MOD_M1 = MOD_LIMIT - 12'd1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_START = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SETUP = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_POST  = 8'b0010_0000,
      ST_CHK   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      STEP_RATIO, STEP_MOD, STEP_RC, STEP_MOD2, STEP_N, STEP_FRAC,
      STEP_GCD, STEP_FRDIV, STEP_MDIV, STEP_BSC, STEP_CLK
   } step_type;

   // Configuration and persistent state
   logic [27:0] ref_freq_ff;
   logic        ref_doubler_ff;
   logic [19:0] chan_step_ff;
   logic [1:0]  power_level_ff;
   logic        power_down_ff;
   logic [9:0]  r_counter_ff, r_counter_in;
   logic [7:0]  out_divider_ff, out_divider_in;
   logic [11:0] modulus_ff, modulus_in;

   // Working registers
   state_type   state_ff, state_in;
   step_type    step_ff, step_in;
   logic        op_ff, op_in;
   logic        rej_ff, rej_in;
   fpll_pkg::status_type st_ff, st_in;
   logic [31:0] f_ff, f_in;
   logic [28:0] pn_ff, pn_in;
   logic [2:0]  sel_ff, sel_in;
   logic        pre_ff, pre_in;
   logic [7:0]  o_ff, o_in;
   logic [9:0]  r_ff, r_in;
   logic [11:0] m_ff, m_in;
   logic [41:0] xr_ff, xr_in;
   logic [NW-1:0] n_ff, n_in;
   logic [28:0] rem_ff, rem_in;
   logic [11:0] fr_ff, fr_in;
   logic [11:0] ga_ff, ga_in;
   logic [11:0] gb_ff, gb_in;
   logic [7:0]  bsc_ff, bsc_in;
   logic [21:0] rm_ff, rm_in;
   logic [11:0] clk_ff, clk_in;
   logic [2:0]  k_ff, k_in;
   logic [NW-1:0] div_a_ff, div_a_in;
   logic [DW-1:0] div_b_ff, div_b_in;
   logic        div_go_ff, div_go_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  num_ff, num_in;
   logic        fs_ff, fs_in;
   logic        last_ff, last_in;
   logic [2:0]  ost_ff, ost_in;

   logic          div_busy, div_done;
   logic [NW-1:0] div_q;
   logic [DW-1:0] div_r;
   logic [29:0]   rs_prod;
   logic [31:0]   d_base;
   logic [DW-1:0] d_full;
   logic [2:0]    sel_calc;
   logic [6:0]    nmin;
   logic [31:0]   w_emit;
   logic          fr_zero;

   fpll_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go_ff),
      .num   (div_a_ff),
      .den   (div_b_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q),
      .rem   (div_r)
   );

   assign rs_prod = 30'(r_ff) * 30'(chan_step_ff);
   assign d_base  = 32'(MOD_M1) * 32'(chan_step_ff);
   assign d_full  = DW'(d_base) << sel_ff;
   assign nmin    = pre_ff ? 7'd75 : 7'd23;
   assign fr_zero = (fr_ff == '0);

   // Output divider select: double while not above the ratio, cap at 64
   always_comb begin
      sel_calc = 3'd6;
      for (int k = 5; k >= 0; k--) begin
         if ((NW'(1) << k) > div_q) sel_calc = 3'(k);
      end
   end

   // Word for the current emission slot
   always_comb begin
      case (k_ff)
         3'd6: w_emit = (32'(fpll_pkg::filter_band(f_ff)) << 7) | (32'd1 << 3) | 32'd6;
         3'd5: w_emit = fpll_pkg::R5_WORD;
         3'd4: w_emit = (32'd1 << 23) | (32'(sel_ff) << 20) | (32'(bsc_ff) << 12)
                        | (32'd1 << 5) | (32'(power_level_ff) << 3) | 32'd4;
         3'd3: w_emit = (fr_zero ? ((32'd1 << 22) | (32'd1 << 21)) : 32'd0)
                        | (32'(clk_ff) << 3) | 32'd3;
         3'd2: w_emit = (32'(ref_doubler_ff) << 25) | (32'(r_ff) << 14) | (32'd8 << 9)
                        | (fr_zero ? ((32'd1 << 8) | (32'd1 << 7)) : 32'd0)
                        | (32'd1 << 6) | (32'(power_down_ff) << 5) | 32'd2;
         3'd1: w_emit = (32'(pre_ff) << 27) | (32'd1 << 15) | (32'(m_ff) << 3) | 32'd1;
         default: w_emit = (32'(n_ff[15:0]) << 15) | (32'(fr_ff) << 3);
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;   step_in = step_ff;   op_in = op_ff;
      rej_in = rej_ff;       st_in = st_ff;       f_in = f_ff;
      pn_in = pn_ff;         sel_in = sel_ff;     pre_in = pre_ff;
      o_in = o_ff;           r_in = r_ff;         m_in = m_ff;
      xr_in = xr_ff;         n_in = n_ff;         rem_in = rem_ff;
      fr_in = fr_ff;         ga_in = ga_ff;       gb_in = gb_ff;
      bsc_in = bsc_ff;       rm_in = rm_ff;       clk_in = clk_ff;
      k_in = k_ff;           div_a_in = div_a_ff; div_b_in = div_b_ff;
      div_go_in = 1'b0;
      r_counter_in = r_counter_ff;
      out_divider_in = out_divider_ff;
      modulus_in = modulus_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      word_in = word_ff; num_in = num_ff; fs_in = fs_ff; last_in = last_ff; ost_in = ost_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               f_in   = req_target_freq;
               pn_in  = ref_doubler_ff ? {ref_freq_ff, 1'b0} : {1'b0, ref_freq_ff};
               r_in   = r_counter_ff;
               o_in   = out_divider_ff;
               m_in   = modulus_ff;
               rej_in = 1'b0;
               st_in  = fpll_pkg::STATUS_OK;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (op_ff) begin
               step_in  = STEP_N;
               state_in = ST_MUL;
            end else if (f_ff < FREQ_MIN || f_ff == '0 || f_ff > FREQ_MAX) begin
               rej_in = 1'b1; st_in = fpll_pkg::STATUS_FREQ_RANGE; state_in = ST_EMIT;
            end else if (chan_step_ff == '0) begin
               rej_in = 1'b1; st_in = fpll_pkg::STATUS_STEP_SMALL; state_in = ST_EMIT;
            end else begin
               step_in  = STEP_RATIO;
               state_in = ST_SETUP;
            end
         end
         ST_MUL: begin
            xr_in    = 42'(f_ff) * 42'(r_ff);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            // Load divider operands for the current step
            div_a_in = NW'(pn_ff);
            div_b_in = DW'(pn_ff);
            case (step_ff)
               STEP_RATIO: begin
                  div_a_in = NW'(fpll_pkg::VCO_LOW_HZ);
                  div_b_in = DW'(f_ff);
               end
               STEP_MOD, STEP_MOD2: div_b_in = DW'(rs_prod) << sel_ff;
               STEP_RC: begin
                  div_a_in = NW'(pn_ff) + NW'(d_full) - NW'(1);
                  div_b_in = d_full;
               end
               STEP_N: div_a_in = NW'(xr_ff) * NW'(o_ff);
               STEP_FRAC: begin
                  div_a_in = ((NW'(rem_ff) * NW'(m_ff)) << 1) + NW'(pn_ff);
                  div_b_in = DW'({pn_ff, 1'b0});
               end
               STEP_GCD: begin
                  div_a_in = NW'(ga_ff);
                  div_b_in = DW'(gb_ff);
               end
               STEP_FRDIV: begin
                  div_a_in = NW'(fr_ff);
                  div_b_in = DW'(gb_ff);
               end
               STEP_MDIV: begin
                  div_a_in = NW'(m_ff);
                  div_b_in = DW'(gb_ff);
               end
               STEP_BSC: div_b_in = DW'(r_ff) * DW'(fpll_pkg::BAND_CLK_HZ);
               STEP_CLK: div_b_in = DW'(rm_ff) * DW'(fpll_pkg::CLK_DIV_UNIT);
               default: ;
            endcase
            div_go_in = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_POST;
         end
         ST_POST: begin
            state_in = ST_SETUP;
            case (step_ff)
               STEP_RATIO: begin
                  sel_in  = sel_calc;
                  o_in    = 8'd1 << sel_calc;
                  pre_in  = f_ff > (fpll_pkg::PRESCALE_HZ >> sel_calc);
                  step_in = STEP_MOD;
               end
               STEP_MOD: begin
                  if (div_q >= NW'(MOD_LIMIT)) begin
                     step_in = STEP_RC;
                  end else begin
                     m_in = div_q[11:0]; step_in = STEP_N; state_in = ST_MUL;
                  end
               end
               STEP_RC: begin
                  if (div_q >= NW'(R_LIMIT)) begin
                     rej_in = 1'b1; st_in = fpll_pkg::STATUS_STEP_SMALL;
                     state_in = ST_EMIT;
                  end else begin
                     r_in = div_q[9:0] + 10'(div_q[0]); step_in = STEP_MOD2;
                  end
               end
               STEP_MOD2: begin
                  m_in = div_q[11:0]; step_in = STEP_N; state_in = ST_MUL;
               end
               STEP_N: begin
                  n_in = div_q; rem_in = div_r[28:0]; step_in = STEP_FRAC;
               end
               STEP_FRAC: begin
                  fr_in = div_q[11:0];
                  if (op_ff) begin
                     k_in = 3'd0; state_in = ST_EMIT;
                  end else if (div_q != '0) begin
                     ga_in = div_q[11:0]; gb_in = m_ff; step_in = STEP_GCD;
                  end else begin
                     state_in = ST_CHK;
                  end
               end
               STEP_GCD: begin
                  if (div_r == '0) begin
                     if (gb_ff > 12'd1) step_in = STEP_FRDIV;
                     else state_in = ST_CHK;
                  end else begin
                     ga_in = gb_ff; gb_in = div_r[11:0];
                  end
               end
               STEP_FRDIV: begin
                  fr_in = div_q[11:0]; step_in = STEP_MDIV;
               end
               STEP_MDIV: begin
                  m_in = div_q[11:0]; state_in = ST_CHK;
               end
               STEP_BSC: begin
                  if (div_q == '0) bsc_in = 8'd1;
                  else if (div_q >= NW'(fpll_pkg::BSC_MAX)) bsc_in = fpll_pkg::BSC_MAX;
                  else bsc_in = div_q[7:0] + 8'd1;
                  rm_in   = 22'(r_ff) * 22'(m_ff);
                  step_in = STEP_CLK;
               end
               STEP_CLK: begin
                  if (div_q >= NW'(fpll_pkg::CLK_MAX)) clk_in = fpll_pkg::CLK_MAX;
                  else clk_in = div_q[11:0] + 12'd1;
                  r_counter_in   = r_ff;
                  out_divider_in = o_ff;
                  modulus_in     = m_ff;
                  k_in     = 3'd6;
                  state_in = ST_EMIT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CHK: begin
            if (m_ff < 12'd2) begin
               rej_in = 1'b1; st_in = fpll_pkg::STATUS_MOD_RANGE; state_in = ST_EMIT;
            end else if (fr_ff > m_ff - 12'd1) begin
               rej_in = 1'b1; st_in = fpll_pkg::STATUS_FRAC_RANGE; state_in = ST_EMIT;
            end else if (n_ff < NW'(nmin) || n_ff > NW'(16'hFFFF)) begin
               rej_in = 1'b1; st_in = fpll_pkg::STATUS_N_RANGE; state_in = ST_EMIT;
            end else begin
               step_in = STEP_BSC; state_in = ST_SETUP;
            end
         end
         ST_EMIT: begin
            // Hand out one word whenever the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (rej_ff) begin
                  word_in = '0; num_in = 3'd0; fs_in = 1'b0; last_in = 1'b1;
                  ost_in = st_ff;
                  state_in = ST_IDLE;
               end else begin
                  word_in = w_emit; num_in = k_ff; fs_in = (k_ff == 3'd6);
                  last_in = (k_ff == 3'd0); ost_in = fpll_pkg::STATUS_OK;
                  if (k_ff == 3'd0) state_in = ST_IDLE;
                  else k_in = k_ff - 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         div_go_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ref_freq_ff    <= 28'd100000000;
         ref_doubler_ff <= 1'b0;
         chan_step_ff   <= 20'd10000;
         power_level_ff <= 2'd0;
         power_down_ff  <= 1'b0;
         r_counter_ff   <= 10'd1;
         out_divider_ff <= 8'd1;
         modulus_ff     <= 12'd0;
      end else begin
         state_ff       <= state_in;
         div_go_ff      <= div_go_in;
         rsp_valid_ff   <= rsp_valid_in;
         r_counter_ff   <= r_counter_in;
         out_divider_ff <= out_divider_in;
         modulus_ff     <= modulus_in;
         // Take configuration transactions
         if (csr_valid) begin
            case (csr_index)
               fpll_pkg::CSR_REF_FREQ:    ref_freq_ff    <= csr_wdata[27:0];
               fpll_pkg::CSR_REF_DOUBLER: ref_doubler_ff <= csr_wdata[0];
               fpll_pkg::CSR_CHAN_STEP:   chan_step_ff   <= csr_wdata[19:0];
               fpll_pkg::CSR_POWER_LEVEL: power_level_ff <= csr_wdata[1:0];
               fpll_pkg::CSR_POWER_DOWN:  power_down_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      step_ff <= step_in;   op_ff <= op_in;     rej_ff <= rej_in;   st_ff <= st_in;
      f_ff <= f_in;         pn_ff <= pn_in;     sel_ff <= sel_in;   pre_ff <= pre_in;
      o_ff <= o_in;         r_ff <= r_in;       m_ff <= m_in;       xr_ff <= xr_in;
      n_ff <= n_in;         rem_ff <= rem_in;   fr_ff <= fr_in;     ga_ff <= ga_in;
      gb_ff <= gb_in;       bsc_ff <= bsc_in;   rm_ff <= rm_in;     clk_ff <= clk_in;
      k_ff <= k_in;         div_a_ff <= div_a_in; div_b_ff <= div_b_in;
      word_ff <= word_in;   num_ff <= num_in;   fs_ff <= fs_in;     last_ff <= last_in;
      ost_ff <= ost_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reg_word      = word_ff;
   assign rsp_reg_number    = num_ff;
   assign rsp_filter_select = fs_ff;
   assign rsp_last_word     = last_ff;
   assign rsp_status        = ost_ff;

`ifndef SYNTHESIS
   a_r_nonzero : assert property (@(posedge clock) disable iff (reset)
      r_counter_ff != '0) else $error("r_counter cleared");
   a_div_pow2 : assert property (@(posedge clock) disable iff (reset)
      $onehot(out_divider_ff)) else $error("output divider not a power of two");
   a_mod_valid : assert property (@(posedge clock) disable iff (reset)
      modulus_ff != 12'd1) else $error("stored modulus of one");
   a_rej_status : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && rej_ff |-> st_ff != fpll_pkg::STATUS_OK)
      else $error("rejection without status");
   a_div_idle : assert property (@(posedge clock) disable iff (reset)
      div_go_ff |-> !div_busy) else $error("divider started while busy");
`endif

endmodule
`default_nettype wire
